/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the fraction unit.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Plain check, disabled while reset is asserted.
`define CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication check, disabled while reset is asserted.
`define CHK_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`endif

/* hdl/frac_pkg.sv */
// Package of the fraction unit: payload structs, operation codes, sizes.
// Depends on nothing.
package frac_pkg;
  localparam int unsigned OpW   = 16;
  localparam int unsigned ProdW = 2 * OpW;
  localparam int unsigned MagW  = ProdW + 1;
  localparam int unsigned NumW  = 33;
  localparam int unsigned DenW  = 31;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_MUL_ALT = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] op;
    logic signed [OpW-1:0] a_num;
    logic signed [OpW-1:0] a_den;
    logic signed [OpW-1:0] b_num;
    logic signed [OpW-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [NumW-1:0] res_num;
    logic [DenW-1:0] res_den;
    logic zero_den_error;
  } res_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic num_neg;
    logic [MagW-1:0] num_mag;
    logic [ProdW-1:0] den_mag;
    logic den_neg;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_MUL1, FS_MUL2, FS_SUM, FS_PUSH
  } fstate_e;

  typedef enum logic [2:0] {
    BS_IDLE, BS_GCD, BS_DIVN, BS_DIVD, BS_OUT
  } bstate_e;
endpackage

/* hdl/frac_front.sv */
// Front part: accepts requests and forms the cross products with two multipliers.
// Depends on frac_pkg.
module frac_front import frac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  input  logic q_full_i,
  output logic push_o,
  output job_t job_o
);
  fstate_e state_q, state_d;
  req_t r_q;
  logic [ProdW-1:0] p1_q, p2_q, den_q;
  logic s1_q, s2_q, sd_q;
  logic an, ad, bn, bd;
  logic [OpW-1:0] man, mad, mbn, mbd, mx, my;
  logic [ProdW-1:0] prod;
  logic sum_neg;
  logic [MagW-1:0] sum_mag;
  logic is_mul;

  function automatic logic [OpW-1:0] mag(input logic [OpW-1:0] v);
    return v[OpW-1] ? (~v + 1'b1) : v;
  endfunction

  assign an = r_q.a_num[OpW-1];
  assign ad = r_q.a_den[OpW-1];
  assign bn = r_q.b_num[OpW-1];
  assign bd = r_q.b_den[OpW-1];
  assign man = mag(r_q.a_num);
  assign mad = mag(r_q.a_den);
  assign mbn = mag(r_q.b_num);
  assign mbd = mag(r_q.b_den);
  assign is_mul = r_q.op[1];

  // Shared multiplier: the denominator product in MUL1, then one numerator product in MUL2.
  always_comb begin
    unique case (state_q)
      FS_MUL1: begin mx = mad; my = mbd; end
      FS_MUL2: begin mx = is_mul ? man : man; my = is_mul ? mbn : mbd; end
      default: begin mx = mbn; my = mad; end
    endcase
  end
  assign prod = ProdW'(mx) * ProdW'(my);

  always_comb begin
    logic [MagW-1:0] x, y;
    logic xn, yn;
    x = MagW'(p2_q);
    xn = s2_q;
    y = MagW'(p1_q);
    yn = s1_q ^ (r_q.op == OP_SUB);
    if (p1_q == '0) yn = 1'b0;
    if (xn == yn) begin
      sum_mag = x + y;
      sum_neg = xn;
    end else if (x >= y) begin
      sum_mag = x - y;
      sum_neg = xn;
    end else begin
      sum_mag = y - x;
      sum_neg = yn;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  always_comb begin
    state_d = state_q;
    push_o = 1'b0;
    job_o.num_neg = is_mul ? s2_q : sum_neg;
    job_o.num_mag = is_mul ? MagW'(p2_q) : sum_mag;
    job_o.den_mag = den_q;
    job_o.den_neg = sd_q;
    unique case (state_q)
      FS_IDLE: if (start_i) state_d = FS_MUL1;
      FS_MUL1: state_d = FS_MUL2;
      FS_MUL2: state_d = is_mul ? FS_PUSH : FS_SUM;
      FS_SUM:  state_d = FS_PUSH;
      FS_PUSH: begin
        if (!q_full_i) begin
          push_o = 1'b1;
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end
  assign busy_o = (state_q != FS_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FS_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FS_IDLE: if (start_i) r_q <= req_i;
      FS_MUL1: begin
        den_q <= prod;
        sd_q <= (prod != '0) && (ad ^ bd);
      end
      FS_MUL2: begin
        p2_q <= prod;
        s2_q <= (prod != '0) && (is_mul ? (an ^ bn) : (an ^ bd));
      end
      FS_SUM: ;
      FS_PUSH: ;
      default: ;
    endcase
    // b_num*a_den product is taken in the cycle after acceptance too.
    if (state_q == FS_MUL1) begin
      p1_q <= ProdW'(mbn) * ProdW'(mad);
      s1_q <= (mbn != '0) && (mad != '0) && (bn ^ ad);
    end
  end
endmodule

/* hdl/frac_queue.sv */
// Short queue between the front and back parts.
// Depends on frac_pkg.
module frac_queue import frac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);
  localparam int unsigned PW = $clog2(QDepth);
  job_t mem_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;

  assign full_o = (cnt_q == (PW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

`include "assert_macros.svh"
  `CHK_IMP(a_no_ovf, clk_i, rst_ni, full_o && !pop_i, !push_i, "queue overflow")
  `CHK_IMP(a_no_unf, clk_i, rst_ni, empty_o, !pop_i, "queue underflow")
  `CHK(a_cnt_max, clk_i, rst_ni, cnt_q <= (PW+1)'(QDepth), "queue count out of range")
endmodule

/* hdl/frac_back.sv */
// Back part: binary gcd, two restoring divisions unless den is zero, result strobe.
// Depends on frac_pkg.
module frac_back import frac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  job_t job_i,
  output logic pop_o,
  output logic valid_o,
  output res_t res_o
);
  localparam int unsigned CW = $clog2(MagW + 1);
  bstate_e state_q, state_d;
  logic [MagW-1:0] u_q, v_q, nm_q, dm_q, g_q, rem_q, quo_q, dvd_q;
  logic [CW-1:0] sh_q, cnt_q;
  logic rneg_q, nneg_q, zero_q;
  logic [MagW:0] trial;
  res_t res_q;

  assign trial = {rem_q, dvd_q[MagW-1]} - {1'b0, g_q};

  always_comb begin
    state_d = state_q;
    pop_o = 1'b0;
    unique case (state_q)
      BS_IDLE: if (!empty_i) begin
        pop_o = 1'b1;
        state_d = BS_GCD;
      end
      BS_GCD: if (zero_q) state_d = BS_OUT;
              else if (u_q == v_q || u_q == '0) state_d = BS_DIVN;
      BS_DIVN: if (cnt_q == CW'(MagW - 1)) state_d = BS_DIVD;
      BS_DIVD: if (cnt_q == CW'(MagW - 1)) state_d = BS_OUT;
      BS_OUT: state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= (state_q == BS_OUT);
    end
  end
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BS_IDLE: begin
        nm_q <= job_i.num_mag;
        dm_q <= MagW'(job_i.den_mag);
        u_q <= job_i.num_mag;
        v_q <= MagW'(job_i.den_mag);
        nneg_q <= job_i.num_neg;
        rneg_q <= (job_i.num_mag != '0) && (job_i.num_neg ^ job_i.den_neg);
        zero_q <= (job_i.den_mag == '0);
        sh_q <= '0;
        cnt_q <= '0;
      end
      BS_GCD: begin
        // Binary gcd: when u reaches zero or equals v, gcd = v << sh.
        if (u_q == v_q || u_q == '0) begin
          g_q <= v_q << sh_q;
          rem_q <= '0;
          dvd_q <= nm_q;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          sh_q <= sh_q + 1'b1;
        end else if (!u_q[0]) u_q <= u_q >> 1;
        else if (!v_q[0]) v_q <= v_q >> 1;
        else if (u_q > v_q) u_q <= (u_q - v_q) >> 1;
        else v_q <= (v_q - u_q) >> 1;
      end
      BS_DIVN, BS_DIVD: begin
        quo_q <= {quo_q[MagW-2:0], !trial[MagW]};
        if (cnt_q == CW'(MagW - 1)) begin
          cnt_q <= '0;
          rem_q <= '0;
          dvd_q <= dm_q;
          if (state_q == BS_DIVN) nm_q <= {quo_q[MagW-2:0], !trial[MagW]};
          else dm_q <= {quo_q[MagW-2:0], !trial[MagW]};
        end else begin
          cnt_q <= cnt_q + 1'b1;
          dvd_q <= dvd_q << 1;
          if (!trial[MagW]) rem_q <= trial[MagW-1:0];
          else rem_q <= {rem_q[MagW-2:0], dvd_q[MagW-1]};
        end
      end
      BS_OUT: begin
        if (zero_q) begin
          res_q.res_num <= nm_q == '0 ? '0 : (nneg_q ? '1 : NumW'(1));
          res_q.res_den <= '0;
          res_q.zero_den_error <= 1'b1;
        end else begin
          res_q.res_num <= rneg_q ? NumW'(~nm_q + 1'b1) : NumW'(nm_q);
          res_q.res_den <= DenW'(dm_q);
          res_q.zero_den_error <= 1'b0;
        end
      end
      default: ;
    endcase
  end

`include "assert_macros.svh"
  `CHK_IMP(a_pop_idle, clk_i, rst_ni, pop_o, state_q == BS_IDLE, "pop outside idle")
  `CHK_IMP(a_valid_err, clk_i, rst_ni, valid_o && res_o.zero_den_error,
           res_o.res_den == '0, "error with nonzero denominator")
  `CHK_IMP(a_valid_idle, clk_i, rst_ni, valid_o, state_q == BS_IDLE, "strobe outside idle")
endmodule

/* hdl/fraction_add_sub_mul_reduce.sv */
// Fraction unit: add, subtract or multiply two 16-bit fractions, reduced result.
// The front steps through MUL1, MUL2, SUM (skipped on multiply) and PUSH; the back
// runs the binary gcd, then divides numerator and denominator (skipped on a zero
// denominator). busy drops once the job is pushed, which waits for room in the queue;
// throughput is set by the back part's gcd and divider; results are not stalled.
// Reset (rst_ni, asynchronous, active low) empties the queue and idles both parts.
module fraction_add_sub_mul_reduce import frac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic valid_o,
  output res_t res_o
);
  // The front computes exact sign-magnitude cross products of each request.
  logic push, full, pop, empty, fbusy;
  job_t fjob, qjob;

  frac_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(fbusy),
    .q_full_i(full), .push_o(push), .job_o(fjob)
  );

  // The queue decouples the short front from the long reduction.
  frac_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(fjob), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qjob)
  );

  // The back reduces by the gcd and emits one strobe per request.
  frac_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(qjob), .pop_o(pop),
    .valid_o, .res_o
  );

  assign busy = fbusy;
endmodule

/* verif/frac_checker.sv */
// Checker of the fraction unit: watches accepted requests and results, predicts
// each reduced fraction and compares it field by field. Depends on frac_pkg.
module frac_checker import frac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic busy,
  input  req_t req_i,
  input  logic valid_o,
  input  res_t res_o,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  res_t reduced_q[$];

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Exact products fit in 64-bit signed arithmetic at this operand width.
  function automatic res_t reduce_fraction(req_t r);
    res_t o;
    longint an, ad, bn, bd, num, den;
    longint unsigned nm, dm, g;
    logic neg;
    an = r.a_num;
    ad = r.a_den;
    bn = r.b_num;
    bd = r.b_den;
    den = ad * bd;
    case (op_e'(r.op))
      OP_ADD: num = an * bd + bn * ad;
      OP_SUB: num = an * bd - bn * ad;
      default: num = an * bn;
    endcase
    o = '0;
    if (den == 0) begin
      o.res_num = (num > 0) ? 33'sd1 : (num < 0) ? -33'sd1 : 33'sd0;
      o.res_den = '0;
      o.zero_den_error = 1'b1;
    end else begin
      nm = (num < 0) ? -num : num;
      dm = (den < 0) ? -den : den;
      neg = (nm != 0) && ((num < 0) != (den < 0));
      g = euclid(nm, dm);
      nm = nm / g;
      dm = dm / g;
      o.res_num = NumW'(neg ? -longint'(nm) : longint'(nm));
      o.res_den = dm[DenW-1:0];
    end
    return o;
  endfunction

  assign pending_count = reduced_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      reduced_q.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) reduced_q.push_back(reduce_fraction(req_i));
      if (valid_o) begin
        if (reduced_q.size() == 0) begin
          $error("result with no request outstanding: %0d/%0d", res_o.res_num, res_o.res_den);
          errs = errs + 1;
        end else begin
          e = reduced_q.pop_front();
          if (res_o.res_num !== e.res_num) begin
            $error("res_num expected %0d actual %0d", e.res_num, res_o.res_num);
            errs = errs + 1;
          end
          if (res_o.res_den !== e.res_den) begin
            $error("res_den expected %0d actual %0d", e.res_den, res_o.res_den);
            errs = errs + 1;
          end
          if (res_o.zero_den_error !== e.zero_den_error) begin
            $error("zero_den_error expected %0b actual %0b", e.zero_den_error,
                   res_o.zero_den_error);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

/* verif/tb_top.sv */
// Testbench top of the fraction unit: clock, reset, request stimulus and verdict.
// Depends on frac_pkg, frac_checker and fraction_add_sub_mul_reduce.
module tb_top;
  import frac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy, valid_o;
  res_t res_o;
  int fail_count, pending_count;
  // Percentage of cycles in which the sender holds off a request.
  int idle_pct = 0;

  always #5 clk_i = ~clk_i;

  fraction_add_sub_mul_reduce dut (.*);
  frac_checker checker_i (.*);

  // Operand values biased toward the edges: zero, ones, extremes, small and wide.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h8000;
      4: return 16'h7FFF;
      5, 6: return 16'($signed($urandom_range(24)) - 12);
      default: return 16'($urandom);
    endcase
  endfunction

  // Drives one request and holds it until the block accepts it. Start stays high
  // across back-to-back requests, so it is never lowered and raised in one step.
  task automatic send_request(logic [1:0] op, logic [15:0] an, logic [15:0] ad,
                              logic [15:0] bn, logic [15:0] bd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{op: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      op = 2'($urandom_range(3));
      send_request(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation, zero denominators, zero numerators, extremes.
    send_request(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_request(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_request(OP_MUL, 16'hFFFE, 16'd4, 16'd3, 16'hFFFA);
    send_request(OP_MUL_ALT, 16'd6, 16'd5, 16'd10, 16'd3);
    send_request(OP_ADD, 16'd5, 16'd0, 16'd1, 16'd7);
    send_request(OP_SUB, 16'hFFFB, 16'd3, 16'd2, 16'd0);
    send_request(OP_MUL, 16'd0, 16'd0, 16'd9, 16'd9);
    send_request(OP_ADD, 16'd0, 16'hFFFF, 16'd0, 16'd5);
    send_request(OP_MUL, 16'd7, 16'hFFF9, 16'd0, 16'd3);
    send_request(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(OP_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_request(OP_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
    send_request(OP_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_request(OP_SUB, 16'h8000, 16'd1, 16'h7FFF, 16'd1);
    send_request(OP_MUL_ALT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);

    // Random phases with different sender idling; results cannot be stalled.
    idle_pct = 0;
    random_phase(150);
    idle_pct = 58;
    random_phase(130);
    idle_pct = 29;
    random_phase(130);
    idle_pct = 0;
    random_phase(120);
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: ends the run in error if the 546 requests and their idle gaps take too long.
  initial begin
    #4ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule
